@@ rtl/fcdma_pkg.sv @@
package fcdma_pkg;

  localparam int ADDR_W = 28;
  localparam int LEN_W  = 17;

  localparam logic [2:0] CMD_CTRL  = 3'd0;
  localparam logic [2:0] CMD_HBL   = 3'd1;
  localparam logic [2:0] CMD_VBL   = 3'd2;
  localparam logic [2:0] CMD_FIFO  = 3'd3;
  localparam logic [2:0] CMD_VIDEO = 3'd4;
  localparam logic [2:0] CMD_BEAT  = 3'd5;

  localparam logic [1:0] MODE_IMM  = 2'd0;
  localparam logic [1:0] MODE_HBL  = 2'd1;
  localparam logic [1:0] MODE_VBL  = 2'd2;
  localparam logic [1:0] MODE_SPEC = 2'd3;

  localparam logic [1:0] STEP_INC    = 2'd0;
  localparam logic [1:0] STEP_DEC    = 2'd1;
  localparam logic [1:0] STEP_FIXED  = 2'd2;
  localparam logic [1:0] STEP_RELOAD = 2'd3;

  localparam logic [ADDR_W-1:0] MASK_INTERNAL = 28'h7FF_FFFF;
  localparam logic [ADDR_W-1:0] MASK_ANY      = 28'hFFF_FFFF;
  localparam logic [LEN_W-1:0]  LEN_MAX_SMALL = 17'h04000;
  localparam logic [LEN_W-1:0]  LEN_MAX_LAST  = 17'h10000;
  localparam logic [7:0]        VIDEO_STOP_LINE = 8'd162;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [1:0]        channel;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [15:0]       word_count;
    logic [15:0]       control_word;
    logic [7:0]        scan_line;
  } in_word_t;

  typedef struct packed {
    logic              xfer_valid;
    logic [1:0]        xfer_channel;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] write_address;
    logic              unit_is_word;
    logic              to_sound_fifo;
    logic              block_end;
    logic [3:0]        irq_pulse;
    logic [3:0]        enabled_mask;
    logic              busy_res;
  } out_word_t;

  // One channel's memory entry.
  typedef struct packed {
    logic [ADDR_W-1:0] cur_source;
    logic [ADDR_W-1:0] cur_dest;
    logic [ADDR_W-1:0] start_dest;
    logic [LEN_W-1:0]  units_left;
    logic [LEN_W-1:0]  block_length;
    logic [1:0]        src_kind;
    logic [1:0]        dst_kind;
    logic              repeat_flag;
    logic              word_flag;
    logic              irq_flag;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

endpackage

@@ rtl/fcdma_ram.sv @@
module fcdma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fcdma_exec.sv @@
// Second stage: applies one command to the channel entry read from memory
// and the flag registers, producing the memory write-back and the result.
module fcdma_exec import fcdma_pkg::*; #(
  parameter int FIFO_BURST = 4
) (
  input  in_word_t    cmd_word,
  input  logic [1:0]  sel,
  input  logic        sel_any,
  input  chan_entry_t entry,
  input  logic [3:0]  en_q,
  input  logic [3:0]  act_q,
  input  logic [7:0]  mode_q,
  output logic        we,
  output chan_entry_t wentry,
  output logic [3:0]  en_d,
  output logic [3:0]  act_d,
  output logic [7:0]  mode_d,
  output out_word_t   res
);

  function automatic logic [ADDR_W-1:0] step_addr(logic [ADDR_W-1:0] a, logic [1:0] k,
                                                   logic [ADDR_W-1:0] sz);
    logic [ADDR_W-1:0] r;
    begin
      case (k)
        STEP_DEC:   r = a - sz;
        STEP_FIXED: r = a;
        default:    r = a + sz;
      endcase
      return r;
    end
  endfunction

  logic [1:0]        c;
  logic [1:0]        cmode;
  logic [15:0]       ctl;
  logic              nfifo;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] amask;
  logic [ADDR_W-1:0] smask;
  logic [ADDR_W-1:0] dmask;
  logic [ADDR_W-1:0] size;
  logic [ADDR_W-1:0] rs;
  logic [ADDR_W-1:0] rd;
  logic              bfifo;
  logic [LEN_W-1:0]  left;

  always_comb begin
    ctl    = cmd_word.control_word;
    c      = (cmd_word.cmd == CMD_BEAT) ? sel : cmd_word.channel;
    cmode  = mode_q[2*c +: 2];
    we     = 1'b0;
    wentry = entry;
    en_d   = en_q;
    act_d  = act_q;
    mode_d = mode_q;
    res    = '0;
    nfifo  = (c == 2'd1 || c == 2'd2) && ctl[13:12] == MODE_SPEC;
    len    = {1'b0, cmd_word.word_count};
    if (cmd_word.word_count == 16'd0) begin
      len = (c == 2'd3) ? LEN_MAX_LAST : LEN_MAX_SMALL;
    end
    if (nfifo) begin
      len = LEN_W'(FIFO_BURST);
    end
    amask = (ctl[10] || nfifo) ? ~ADDR_W'(3) : ~ADDR_W'(1);
    smask = (c == 2'd0) ? MASK_INTERNAL : MASK_ANY;
    dmask = (c == 2'd3) ? MASK_ANY : MASK_INTERNAL;
    bfifo = (c == 2'd1 || c == 2'd2) && cmode == MODE_SPEC;
    size  = entry.word_flag ? ADDR_W'(4) : ADDR_W'(2);
    rs    = entry.cur_source & smask;
    rd    = entry.cur_dest & dmask;
    left  = (entry.units_left != '0) ? entry.units_left - 1'b1 : entry.units_left;
    unique case (cmd_word.cmd)
      CMD_CTRL: begin
        en_d[c] = ctl[15];
        if (!ctl[15]) begin
          act_d[c] = 1'b0;
        end else if (!en_q[c]) begin
          we                  = 1'b1;
          mode_d[2*c +: 2]    = ctl[13:12];
          wentry.dst_kind     = nfifo ? STEP_RELOAD : ctl[6:5];
          wentry.src_kind     = ctl[8:7];
          wentry.repeat_flag  = ctl[9];
          wentry.word_flag    = ctl[10] | nfifo;
          wentry.irq_flag     = ctl[14];
          wentry.units_left   = len;
          wentry.block_length = len;
          wentry.cur_source   = cmd_word.source_address & amask;
          wentry.cur_dest     = cmd_word.dest_address & amask;
          wentry.start_dest   = cmd_word.dest_address & amask;
          act_d[c]            = ctl[13:12] == MODE_IMM;
        end
      end
      CMD_HBL, CMD_VBL: begin
        for (int i = 0; i < 4; i++) begin
          if (en_q[i] && mode_q[2*i +: 2] == cmd_word.cmd[1:0]) begin
            act_d[i] = 1'b1;
          end
        end
      end
      CMD_FIFO: begin
        if ((c == 2'd1 || c == 2'd2) && en_q[c] && cmode == MODE_SPEC) begin
          act_d[c] = 1'b1;
        end
      end
      CMD_VIDEO: begin
        if (en_q[3] && mode_q[7:6] == MODE_SPEC) begin
          if (cmd_word.scan_line == VIDEO_STOP_LINE) begin
            en_d[3]  = 1'b0;
            act_d[3] = 1'b0;
          end else begin
            act_d[3] = 1'b1;
          end
        end
      end
      CMD_BEAT: begin
        if (sel_any) begin
          we                 = 1'b1;
          res.xfer_valid     = 1'b1;
          res.xfer_channel   = c;
          res.read_address   = rs;
          res.write_address  = rd;
          res.unit_is_word   = entry.word_flag;
          res.to_sound_fifo  = bfifo;
          wentry.cur_source  = step_addr(rs, entry.src_kind, size);
          wentry.cur_dest    = bfifo ? rd : step_addr(rd, entry.dst_kind, size);
          wentry.units_left  = left;
          if (left == '0) begin
            res.block_end = 1'b1;
            res.irq_pulse = entry.irq_flag ? (4'd1 << c) : 4'd0;
            act_d[c]      = 1'b0;
            if (entry.repeat_flag && cmode != MODE_IMM) begin
              wentry.units_left = entry.block_length;
              if (entry.dst_kind == STEP_RELOAD) begin
                wentry.cur_dest = entry.start_dest;
              end
            end else begin
              en_d[c] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    res.enabled_mask = en_d;
    res.busy_res     = |act_d;
  end

endmodule

@@ rtl/four_channel_dma_controller_unit.sv @@
// Four-channel DMA address sequencer. Each accepted command word yields
// exactly one result word. Commands: control write, hblank, vblank, FIFO
// request, video line, and beat; a beat emits one masked read/write address
// pair from the lowest-numbered active channel. Per-channel addresses and
// counts live in a four-entry synchronous RAM read as each word is accepted;
// enable, active and start-mode bits are flip-flops so triggers act on all
// channels at once. The pipeline has two stages (RAM read, then modify and
// write back) and takes one word per cycle while the output does not stall;
// the result is registered at the end of the second stage. Back-to-back
// words on the same channel are handled by forwarding the just-written entry
// over the RAM read data. While the output stalls, the RAM keeps reading the
// entry of the word held in stage 1. No clearing pass is needed: an entry
// is always written by its enabling control write before it is used.
module four_channel_dma_controller_unit import fcdma_pkg::*; #(
  parameter int FIFO_BURST = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [3:0] en_q, act_q, en_d, act_d;
  logic [7:0] mode_q, mode_d;

  // Stage 1 holds the accepted word; its channel pick was made at accept
  // from the flags as they will stand when it executes.
  logic       s1_valid;
  in_word_t   s1_word;
  logic [1:0] s1_sel;
  logic       s1_any;
  logic [1:0] s1_addr;

  logic        we;
  chan_entry_t wentry, rentry, entry;
  logic        fwd;
  chan_entry_t fwd_entry;
  out_word_t   res;

  logic       stall;
  logic       adv;
  logic [3:0] act_next;
  logic [1:0] pick;
  logic       pick_any;
  logic [1:0] raddr;

  // The pipeline stalls while a result waits in the output register.
  assign stall    = out_valid && !out_ready;
  assign adv      = s1_valid && !stall;
  assign in_ready = !stall;
  assign act_next = adv ? act_d : act_q;
  assign s1_addr  = (s1_word.cmd == CMD_BEAT) ? s1_sel : s1_word.channel;

  always_comb begin
    pick     = 2'd0;
    pick_any = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (act_next[i]) begin
        pick     = 2'(i);
        pick_any = 1'b1;
      end
    end
    if (stall) begin
      raddr = s1_addr;
    end else begin
      raddr = (in_data.cmd == CMD_BEAT) ? pick : in_data.channel;
    end
  end

  fcdma_ram #(.WIDTH(ENTRY_W), .DEPTH(4)) u_ram (
    .clk   (clk),
    .we    (adv && we),
    .waddr (s1_addr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  assign entry = fwd ? fwd_entry : rentry;

  fcdma_exec #(.FIFO_BURST(FIFO_BURST)) u_exec (
    .cmd_word (s1_word),
    .sel      (s1_sel),
    .sel_any  (s1_any),
    .entry    (entry),
    .en_q     (en_q),
    .act_q    (act_q),
    .mode_q   (mode_q),
    .we       (we),
    .wentry   (wentry),
    .en_d     (en_d),
    .act_d    (act_d),
    .mode_d   (mode_d),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q      <= '0;
      act_q     <= '0;
      mode_q    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      if (adv) begin
        en_q   <= en_d;
        act_q  <= act_d;
        mode_q <= mode_d;
      end
      if (!stall) begin
        s1_valid  <= in_valid;
        out_valid <= s1_valid;
        fwd       <= adv && we && in_valid && (raddr == s1_addr);
      end
    end
    if (!stall) begin
      s1_word   <= in_data;
      s1_sel    <= pick;
      s1_any    <= pick_any;
      fwd_entry <= wentry;
      if (s1_valid) begin
        out_data <= res;
      end
    end
  end

  // A beat only fires on a channel that is active.
  a_beat_active: assert property (@(posedge clk) disable iff (rst)
    adv && res.xfer_valid |-> act_q[res.xfer_channel])
    else $error("beat on inactive channel");
  // An active channel is always enabled.
  a_act_en: assert property (@(posedge clk) disable iff (rst) (act_q & ~en_q) == 4'd0)
    else $error("active channel not enabled");
  // Interrupts only come with the end of a block.
  a_irq_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.irq_pulse != 4'd0 |-> out_data.block_end)
    else $error("irq without block end");
  // A stalled result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_ready) && !$past(rst) |-> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule
